/* hdl/opi_pkg.sv */
// Shared constants, widths and the CORDIC arctangent table for the pose integrator.
`timescale 1ns / 1ps

package opi_pkg;

   // Angle constants in centidegrees.
   localparam int FULL_TURN    = 36000;
   localparam int HALF_TURN    = 18000;
   localparam int QUARTER_TURN = 9000;

   // Reciprocal of the CORDIC gain in Q20.
   localparam int INV_GAIN_Q20 = 636751;

   // CORDIC iteration count limits.
   localparam int DEF_CORDIC_STEPS = 16;
   localparam int MAX_CORDIC_STEPS = 24;

   // Field and datapath widths.
   localparam int POS_W      = 32;
   localparam int DELTA_W    = 16;
   localparam int YAW_W      = 16;
   localparam int SCALE_W    = 24;
   localparam int OFFSET_W   = 16;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;
   localparam int PROD_W     = 41;
   localparam int VEC_W      = 42;
   localparam int ANG_W      = 32;
   localparam int ANG_FRAC_W = 16;
   localparam int FRAC_SH    = 20;
   localparam int MUL_A_W    = 25;
   localparam int MUL_B_W    = 21;
   localparam int MUL_P_W    = 46;
   localparam int ATAN_IDX_W = 5;

   // Register reset values.
   localparam logic [SCALE_W-1:0]  SCALE_RESET  = SCALE_W'(65536);
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = '0;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET = CSR_IDX_W'(1);

   // Arctangent of 2^-i in centidegrees Q16.
   function automatic logic signed [ANG_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [ANG_W-1:0] val;
      case (idx)
         5'd0:    val = 32'sd294912000;
         5'd1:    val = 32'sd174096719;
         5'd2:    val = 32'sd91987925;
         5'd3:    val = 32'sd46694507;
         5'd4:    val = 32'sd23437865;
         5'd5:    val = 32'sd11730358;
         5'd6:    val = 32'sd5866610;
         5'd7:    val = 32'sd2933484;
         5'd8:    val = 32'sd1466764;
         5'd9:    val = 32'sd733385;
         5'd10:   val = 32'sd366693;
         5'd11:   val = 32'sd183347;
         5'd12:   val = 32'sd91673;
         5'd13:   val = 32'sd45837;
         5'd14:   val = 32'sd22918;
         5'd15:   val = 32'sd11459;
         5'd16:   val = 32'sd5730;
         5'd17:   val = 32'sd2865;
         5'd18:   val = 32'sd1432;
         5'd19:   val = 32'sd716;
         5'd20:   val = 32'sd358;
         5'd21:   val = 32'sd179;
         5'd22:   val = 32'sd90;
         5'd23:   val = 32'sd45;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

/* hdl/odometry_pose_integrator.sv */
// Top level of the 2D dead-reckoning pose integrator with an iterative CORDIC rotator.
`timescale 1ns / 1ps

// Usage:
// The req_ channel takes one odometry word: an integrate sample (sensor deltas and an
// absolute yaw) or a direct pose load. Every accepted word returns one word on the rsp_
// channel holding the pose after the update: pos_x, pos_y (Q16.16) and heading.
// The csr_ channel writes scale_q16 (index 0) and yaw_offset (index 1); it is always
// ready. The user must write it only while no word is in flight; the block does not
// enforce this. Other indexes are ignored. An integrate word passes through the
// multiply, rotate, CORDIC step, accumulate and publish states before rsp_valid; a
// load word goes straight to publish. The integrate time is set by the single shared
// multiplier, used six times to scale and prescale both deltas, and by the CORDIC
// step unit that runs once per step. req_ready is high only while the sequencer is idle.
// The result sits in its own output register, so a new word may be accepted while the
// previous result still waits; if the receiver stalls longer, the next result waits in
// the sequencer until the register frees.
// Reset clears the pose to zero, restores scale_q16 to 1.0 and yaw_offset to zero, and
// drops any word in flight.
module odometry_pose_integrator
   import opi_pkg::*;
#(
   parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
   input  logic                        clock,
   input  logic                        reset,
   // Input channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_operation,
   input  logic signed [DELTA_W-1:0]   req_delta_x,
   input  logic signed [DELTA_W-1:0]   req_delta_y,
   input  logic signed [YAW_W-1:0]     req_yaw_in,
   input  logic signed [POS_W-1:0]     req_load_x,
   input  logic signed [POS_W-1:0]     req_load_y,
   input  logic        [YAW_W-1:0]     req_load_yaw,
   // Result channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [POS_W-1:0]     rsp_pos_x,
   output logic signed [POS_W-1:0]     rsp_pos_y,
   output logic        [YAW_W-1:0]     rsp_heading,
   // Configuration channel
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic        [CSR_IDX_W-1:0] csr_index,
   input  logic        [CSR_DATA_W-1:0] csr_wdata
);

   localparam int StepW     = $clog2(CORDIC_STEPS);
   localparam int YawExtW   = 18;

   // Sequencer state codes.
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MX   = 4'd1;
   localparam logic [3:0] S_HX   = 4'd2;
   localparam logic [3:0] S_LX   = 4'd3;
   localparam logic [3:0] S_MY   = 4'd4;
   localparam logic [3:0] S_HY   = 4'd5;
   localparam logic [3:0] S_LY   = 4'd6;
   localparam logic [3:0] S_ROT  = 4'd7;
   localparam logic [3:0] S_STEP = 4'd8;
   localparam logic [3:0] S_ACC  = 4'd9;
   localparam logic [3:0] S_PUB  = 4'd10;

   // Saturate a wide signed sum to the signed position range.
   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [VEC_W:0] v);
      logic fits;
      fits = (v[VEC_W:POS_W-1] == '0) || (v[VEC_W:POS_W-1] == '1);
      if (fits) begin
         return v[POS_W-1:0];
      end else if (v[VEC_W]) begin
         return {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         return {1'b0, {(POS_W-1){1'b1}}};
      end
   endfunction

   // Control and state registers.
   logic [3:0]                  state_ff, state_in;
   logic [StepW-1:0]            step_cnt_ff, step_cnt_in;
   logic [SCALE_W-1:0]          scale_ff, scale_in;
   logic [OFFSET_W-1:0]         yaw_offset_ff, yaw_offset_in;
   logic signed [POS_W-1:0]     acc_x_ff, acc_x_in;
   logic signed [POS_W-1:0]     acc_y_ff, acc_y_in;
   logic [YAW_W-1:0]            yaw_reg_ff, yaw_reg_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic signed [DELTA_W-1:0]   dx_ff, dx_in;
   logic signed [DELTA_W-1:0]   dy_ff, dy_in;
   logic signed [YAW_W-1:0]     yi_ff, yi_in;
   logic [YAW_W-1:0]            yaw_r_ff, yaw_r_in;
   logic signed [PROD_W-1:0]    m_ff, m_in;
   logic signed [VEC_W-1:0]     x_ff, x_in;
   logic signed [VEC_W-1:0]     y_ff, y_in;
   logic signed [ANG_W-1:0]     z_ff, z_in;
   logic signed [POS_W-1:0]     out_x_ff, out_x_in;
   logic signed [POS_W-1:0]     out_y_ff, out_y_in;
   logic [YAW_W-1:0]            out_yaw_ff, out_yaw_in;

   // Shared multiplier.
   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]   mul_b;
   logic signed [MUL_P_W-1:0]   mul_p;

   // Helper signals.
   logic signed [YawExtW-1:0]   yaw_s, yaw_s1, yaw_r0, yaw_r1, yaw_r2;
   logic signed [YawExtW-1:0]   phi, phi0, phi1;
   logic [PROD_W-1:0]           lo_sum;
   logic signed [VEC_W-1:0]     lo_rnd;
   logic signed [VEC_W-1:0]     x_sh, y_sh;
   logic signed [ANG_W-1:0]     atan_val;
   logic                        dir_pos;
   logic                        out_free;

   assign req_ready   = (state_ff == S_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_x   = out_x_ff;
   assign rsp_pos_y   = out_y_ff;
   assign rsp_heading = out_yaw_ff;
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MX: begin
            mul_a = $signed(MUL_A_W'(scale_ff));
            mul_b = MUL_B_W'(dx_ff);
         end
         S_MY: begin
            mul_a = $signed(MUL_A_W'(scale_ff));
            mul_b = MUL_B_W'(dy_ff);
         end
         S_HX, S_HY: begin
            mul_a = MUL_A_W'($signed(m_ff[PROD_W-1:FRAC_SH]));
            mul_b = MUL_B_W'(INV_GAIN_Q20);
         end
         S_LX, S_LY: begin
            mul_a = $signed(MUL_A_W'(m_ff[FRAC_SH-1:0]));
            mul_b = MUL_B_W'(INV_GAIN_Q20);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Rounded low partial product of the gain prescale.
   assign lo_sum = mul_p[PROD_W-1:0] + PROD_W'(1 << (FRAC_SH - 1));
   assign lo_rnd = $signed(VEC_W'(lo_sum[PROD_W-1:FRAC_SH]));

   // Heading: shift by a half turn, wrap, remove the offset and wrap again.
   always_comb begin
      yaw_s = YawExtW'(yi_ff) + YawExtW'(HALF_TURN);
      if (yaw_s > YawExtW'(FULL_TURN)) begin
         yaw_s1 = yaw_s - YawExtW'(FULL_TURN);
      end else if (yaw_s < 0) begin
         yaw_s1 = yaw_s + YawExtW'(FULL_TURN);
      end else begin
         yaw_s1 = yaw_s;
      end
      yaw_r0 = yaw_s1 - $signed(YawExtW'(yaw_offset_ff));
      yaw_r1 = (yaw_r0 < 0) ? yaw_r0 + YawExtW'(FULL_TURN) : yaw_r0;
      yaw_r2 = (yaw_r1 < 0) ? yaw_r1 + YawExtW'(FULL_TURN) : yaw_r1;
   end

   // Rotation angle is the negated heading folded into a half turn.
   always_comb begin
      phi  = -$signed(YawExtW'(yaw_r_ff));
      phi0 = (phi <= -YawExtW'(HALF_TURN)) ? phi + YawExtW'(FULL_TURN) : phi;
      if (phi0 > YawExtW'(QUARTER_TURN)) begin
         phi1 = phi0 - YawExtW'(QUARTER_TURN);
      end else if (phi0 < -YawExtW'(QUARTER_TURN)) begin
         phi1 = phi0 + YawExtW'(QUARTER_TURN);
      end else begin
         phi1 = phi0;
      end
   end

   // One CORDIC micro-rotation.
   assign x_sh     = x_ff >>> step_cnt_ff;
   assign y_sh     = y_ff >>> step_cnt_ff;
   assign atan_val = atan_q16(ATAN_IDX_W'(step_cnt_ff));
   assign dir_pos  = !z_ff[ANG_W-1];

   // Sequencer and next-state values.
   always_comb begin
      state_in      = state_ff;
      step_cnt_in   = step_cnt_ff;
      scale_in      = scale_ff;
      yaw_offset_in = yaw_offset_ff;
      acc_x_in      = acc_x_ff;
      acc_y_in      = acc_y_ff;
      yaw_reg_in    = yaw_reg_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      yi_in         = yi_ff;
      yaw_r_in      = yaw_r_ff;
      m_in          = m_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      out_x_in      = out_x_ff;
      out_y_in      = out_y_ff;
      out_yaw_in    = out_yaw_ff;

      // Configuration writes.
      if (csr_valid) begin
         if (csr_index == CSR_SCALE) begin
            scale_in = csr_wdata[SCALE_W-1:0];
         end else if (csr_index == CSR_OFFSET) begin
            yaw_offset_in = csr_wdata[OFFSET_W-1:0];
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_operation) begin
                  acc_x_in   = req_load_x;
                  acc_y_in   = req_load_y;
                  yaw_reg_in = req_load_yaw;
                  state_in   = S_PUB;
               end else begin
                  dx_in    = req_delta_x;
                  dy_in    = req_delta_y;
                  yi_in    = req_yaw_in;
                  state_in = S_MX;
               end
            end
         end
         S_MX: begin
            m_in     = PROD_W'(-mul_p);
            yaw_r_in = yaw_r2[YAW_W-1:0];
            state_in = S_HX;
         end
         S_HX: begin
            x_in     = VEC_W'(mul_p);
            state_in = S_LX;
         end
         S_LX: begin
            x_in     = x_ff + lo_rnd;
            state_in = S_MY;
         end
         S_MY: begin
            m_in     = PROD_W'(mul_p);
            state_in = S_HY;
         end
         S_HY: begin
            y_in     = VEC_W'(mul_p);
            state_in = S_LY;
         end
         S_LY: begin
            y_in     = y_ff + lo_rnd;
            state_in = S_ROT;
         end
         S_ROT: begin
            // Exact quarter turn first when the angle lies beyond a quarter.
            if (phi0 > YawExtW'(QUARTER_TURN)) begin
               x_in = -y_ff;
               y_in = x_ff;
            end else if (phi0 < -YawExtW'(QUARTER_TURN)) begin
               x_in = y_ff;
               y_in = -x_ff;
            end
            z_in        = ANG_W'(phi1) <<< ANG_FRAC_W;
            step_cnt_in = '0;
            state_in    = S_STEP;
         end
         S_STEP: begin
            if (dir_pos) begin
               x_in = x_ff - y_sh;
               y_in = y_ff + x_sh;
               z_in = z_ff - atan_val;
            end else begin
               x_in = x_ff + y_sh;
               y_in = y_ff - x_sh;
               z_in = z_ff + atan_val;
            end
            if (step_cnt_ff == StepW'(CORDIC_STEPS - 1)) begin
               state_in = S_ACC;
            end else begin
               step_cnt_in = step_cnt_ff + 1'b1;
            end
         end
         S_ACC: begin
            acc_x_in   = sat_pos((VEC_W + 1)'(acc_x_ff) + (VEC_W + 1)'(x_ff));
            acc_y_in   = sat_pos((VEC_W + 1)'(acc_y_ff) + (VEC_W + 1)'(y_ff));
            yaw_reg_in = yaw_r_ff;
            state_in   = S_PUB;
         end
         S_PUB: begin
            // Move the pose into the output register once it is free.
            if (out_free) begin
               out_x_in     = acc_x_ff;
               out_y_in     = acc_y_ff;
               out_yaw_in   = yaw_reg_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         step_cnt_ff   <= '0;
         scale_ff      <= SCALE_RESET;
         yaw_offset_ff <= OFFSET_RESET;
         acc_x_ff      <= '0;
         acc_y_ff      <= '0;
         yaw_reg_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_cnt_ff   <= step_cnt_in;
         scale_ff      <= scale_in;
         yaw_offset_ff <= yaw_offset_in;
         acc_x_ff      <= acc_x_in;
         acc_y_ff      <= acc_y_in;
         yaw_reg_ff    <= yaw_reg_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Datapath registers without reset.
   always_ff @(posedge clock) begin
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      yi_ff      <= yi_in;
      yaw_r_ff   <= yaw_r_in;
      m_ff       <= m_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      out_x_ff   <= out_x_in;
      out_y_ff   <= out_y_in;
      out_yaw_ff <= out_yaw_in;
   end

   // The wrapped heading never exceeds a full turn.
   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROT) |-> (yaw_r_ff <= YAW_W'(FULL_TURN)))
      else $error("wrapped heading out of range");

   // After the quarter-turn fold the residual angle lies within a quarter turn.
   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROT) |=>
         ((z_ff <= 32'sd589824000) && (z_ff >= -32'sd589824000)))
      else $error("CORDIC start angle beyond a quarter turn");

   // The residual angle stays bounded while the rotator converges.
   a_z_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP) |-> ((z_ff < 32'sd1073741824) && (z_ff > -32'sd1073741824)))
      else $error("CORDIC residual angle diverged");

   // A result appears only from the publish step.
   a_pub_only: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_PUB))
      else $error("result word raised outside the publish step");

endmodule
